// File: rtl/core/fta_pkg.sv
package fta_pkg;

    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int BASE_W     = 12;
    localparam int LEVEL_W    = 13;
    localparam int ANGLE_W    = 16;
    localparam int OUT_W      = ((ANGLE_W + 2 * LEVEL_W + 7) / 8) * 8;

    localparam int ALPHA_FRAC = 16;
    localparam int ALPHA_HALF = 32768;
    localparam logic [CFG_W-1:0]  ALPHA_ONE = 17'd65536;
    localparam logic [CFG_W-1:0]  ALPHA_RST = 17'd6554;
    localparam logic [BASE_W-1:0] BASE_RST  = 12'd2100;
    localparam logic [BASE_W-1:0] ZERO_RST  = 12'd550;

    // CORDIC input scaling, angle accumulator in 1/32768 degree
    localparam int CORDIC_SHIFT = 16;
    localparam int ATAN_LEN     = 24;
    localparam int ATAN_W       = 21;
    localparam int Z_W          = 25;
    localparam int QUARTER      = 90 * 32768;
    localparam int ROUND_HALF   = 128;
    localparam int ANGLE_LIMIT  = 23040;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALPHA = 2'd0,
        REG_BASE  = 2'd1,
        REG_ZERO  = 2'd2
    } t_reg_idx;

    // atan(2^-i) in 1/32768 degree, rounded
    function automatic logic [ATAN_W-1:0] atan_units(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 21'd1474560;
            5'd1:    v = 21'd870484;
            5'd2:    v = 21'd459940;
            5'd3:    v = 21'd233473;
            5'd4:    v = 21'd117189;
            5'd5:    v = 21'd58652;
            5'd6:    v = 21'd29333;
            5'd7:    v = 21'd14667;
            5'd8:    v = 21'd7334;
            5'd9:    v = 21'd3667;
            5'd10:   v = 21'd1833;
            5'd11:   v = 21'd917;
            5'd12:   v = 21'd458;
            5'd13:   v = 21'd229;
            5'd14:   v = 21'd115;
            5'd15:   v = 21'd57;
            5'd16:   v = 21'd29;
            5'd17:   v = 21'd14;
            5'd18:   v = 21'd7;
            5'd19:   v = 21'd4;
            5'd20:   v = 21'd2;
            5'd21:   v = 21'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/filtered_tilt_angle.sv
// Throughput: one item per cycle while the output is not stalled; the filter update is the only loop,
// and the CORDIC runs as one registered stage per step.
// Reset (synchronous, active low): filter state cleared, registers to their defaults,
// pipeline emptied.
module filtered_tilt_angle #(
    parameter int SAMPLE_BITS  = fta_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = fta_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = fta_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fta_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [fta_pkg::CFG_W-1:0]              i_cfg_wdata,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // sample_x, sample_y
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // tilt_angle[15:0], level_x[28:16], level_y[41:29]
    output logic [fta_pkg::OUT_W-1:0]              o_m_axis_tdata
);
    import fta_pkg::*;

    localparam int DW = (SAMPLE_BITS > BASE_W ? SAMPLE_BITS : BASE_W) + 1;
    localparam int SW = DW + FRAC_BITS;
    localparam int EW = SW + 1;
    localparam int PW = EW + CFG_W + 1;
    localparam int CW = DW + 1;
    localparam int XW = CW + CORDIC_SHIFT + 3;
    localparam int N  = CORDIC_STEPS;

    function automatic logic signed [SW-1:0] filt_step(
        input logic signed [SW-1:0] s,
        input logic signed [DW-1:0] d,
        input logic [CFG_W-1:0]     a
    );
        logic signed [EW-1:0] e;
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        // s' = s + round(a * (d*2^F - s) / 2^16)
        e = (EW'(d) <<< FRAC_BITS) - EW'(s);
        p = PW'(e) * PW'(signed'({1'b0, a}));
        q = (p + PW'(ALPHA_HALF)) >>> ALPHA_FRAC;
        return s + SW'(q);
    endfunction

    function automatic logic signed [DW-1:0] trunc_level(input logic signed [SW-1:0] s);
        logic signed [DW-1:0] t;
        t = DW'(s >>> FRAC_BITS);
        if (s[SW-1] && (|s[FRAC_BITS-1:0])) begin
            t = t + DW'(1);
        end
        return t;
    endfunction

    logic [CFG_W-1:0]  r_alpha;
    logic [BASE_W-1:0] r_base;
    logic [BASE_W-1:0] r_zero;

    logic signed [SW-1:0] r_sx, r_sy;
    logic                 r_va;

    logic signed [XW-1:0]      r_x   [0:N];
    logic signed [XW-1:0]      r_y   [0:N];
    logic signed [Z_W-1:0]     r_z   [0:N];
    logic [LEVEL_W-1:0]        r_lx  [0:N];
    logic [LEVEL_W-1:0]        r_ly  [0:N];
    logic                      r_nz  [0:N];
    logic [N:0]                r_vld;

    logic signed [XW-1:0]      n_x   [0:N];
    logic signed [XW-1:0]      n_y   [0:N];
    logic signed [Z_W-1:0]     n_z   [0:N];
    logic [LEVEL_W-1:0]        n_lx  [0:N];
    logic [LEVEL_W-1:0]        n_ly  [0:N];
    logic                      n_nz  [0:N];
    logic [N:0]                n_vld;

    logic                  r_ovld;
    logic [ANGLE_W-1:0]    r_angle;
    logic [LEVEL_W-1:0]    r_olx, r_oly;

    logic [N:0]            w_rdy;
    logic                  w_rdy_out;
    logic                  w_acc;
    logic [CFG_W-1:0]      w_alpha;
    logic signed [DW-1:0]  w_dx, w_dy;
    logic signed [DW-1:0]  w_tx, w_ty;
    logic signed [CW-1:0]  w_cx, w_cy;
    logic signed [XW-1:0]  w_xs, w_ys;
    logic signed [Z_W:0]   w_zr;
    logic signed [Z_W-8:0] w_rnd;
    logic [ANGLE_W-1:0]    w_angle;

    // ready ripples back through the stages so bubbles collapse
    always_comb begin
        w_rdy_out = !r_ovld || i_m_axis_tready;
        w_rdy[N]  = !r_vld[N] || w_rdy_out;
        for (int k = N - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_s_axis_tready = !r_va || w_rdy[0];
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // filter input
    always_comb begin
        w_alpha = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        w_dx = signed'(DW'(i_s_axis_tdata[SAMPLE_BITS-1:0])) - signed'(DW'(r_base));
        w_dy = signed'(DW'(i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]))
               - signed'(DW'(r_base));
    end

    // centre, scale and fold into the right half-plane
    always_comb begin
        w_tx = trunc_level(r_sx);
        w_ty = trunc_level(r_sy);
        w_cx = CW'(w_tx) - signed'(CW'(r_zero));
        w_cy = CW'(w_ty) - signed'(CW'(r_zero));
        w_xs = XW'(w_cx) <<< CORDIC_SHIFT;
        w_ys = XW'(w_cy) <<< CORDIC_SHIFT;
        n_lx[0]  = w_tx[LEVEL_W-1:0];
        n_ly[0]  = w_ty[LEVEL_W-1:0];
        n_nz[0]  = (w_cx == '0) && (w_cy == '0);
        n_vld[0] = r_va;
        if (w_cx < 0) begin
            if (w_cy >= 0) begin
                n_x[0] = w_ys;
                n_y[0] = -w_xs;
                n_z[0] = Z_W'(QUARTER);
            end else begin
                n_x[0] = -w_ys;
                n_y[0] = w_xs;
                n_z[0] = Z_W'(-QUARTER);
            end
        end else begin
            n_x[0] = w_xs;
            n_y[0] = w_ys;
            n_z[0] = '0;
        end

        // one vectoring step per stage
        for (int k = 1; k <= N; k++) begin
            n_lx[k]  = r_lx[k-1];
            n_ly[k]  = r_ly[k-1];
            n_nz[k]  = r_nz[k-1];
            n_vld[k] = r_vld[k-1];
            if (r_y[k-1] > 0) begin
                n_x[k] = r_x[k-1] + (r_y[k-1] >>> (k - 1));
                n_y[k] = r_y[k-1] - (r_x[k-1] >>> (k - 1));
                n_z[k] = r_z[k-1] + signed'(Z_W'(atan_units(5'(k - 1))));
            end else begin
                n_x[k] = r_x[k-1] - (r_y[k-1] >>> (k - 1));
                n_y[k] = r_y[k-1] + (r_x[k-1] >>> (k - 1));
                n_z[k] = r_z[k-1] - signed'(Z_W'(atan_units(5'(k - 1))));
            end
        end
    end

    // round to 1/128 degree, clamp at half a turn
    always_comb begin
        w_zr  = (Z_W+1)'(r_z[N]) + (Z_W+1)'(ROUND_HALF);
        w_rnd = w_zr[Z_W:8];
        if (r_nz[N]) begin
            w_angle = '0;
        end else if (w_rnd > ANGLE_LIMIT) begin
            w_angle = ANGLE_W'(ANGLE_LIMIT);
        end else if (w_rnd < -ANGLE_LIMIT) begin
            w_angle = ANGLE_W'(-ANGLE_LIMIT);
        end else begin
            w_angle = ANGLE_W'(w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_base  <= BASE_RST;
            r_zero  <= ZERO_RST;
            r_sx    <= '0;
            r_sy    <= '0;
            r_va    <= 1'b0;
            r_vld   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ALPHA: r_alpha <= i_cfg_wdata;
                    REG_BASE:  r_base  <= i_cfg_wdata[BASE_W-1:0];
                    REG_ZERO:  r_zero  <= i_cfg_wdata[BASE_W-1:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_sx <= filt_step(r_sx, w_dx, w_alpha);
                r_sy <= filt_step(r_sy, w_dy, w_alpha);
            end
            if (o_s_axis_tready) begin
                r_va <= w_acc;
            end
            for (int k = 0; k <= N; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
            if (w_rdy_out) begin
                r_ovld <= r_vld[N];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= N; k++) begin
            if (w_rdy[k]) begin
                r_x[k]  <= n_x[k];
                r_y[k]  <= n_y[k];
                r_z[k]  <= n_z[k];
                r_lx[k] <= n_lx[k];
                r_ly[k] <= n_ly[k];
                r_nz[k] <= n_nz[k];
            end
        end
        if (w_rdy_out) begin
            r_angle <= w_angle;
            r_olx   <= r_lx[N];
            r_oly   <= r_ly[N];
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = OUT_W'({r_oly, r_olx, r_angle});

endmodule

// File: rtl/core/fta_chk.sv
module fta_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [fta_pkg::OUT_W-1:0]          o_m_axis_tdata
);
    import fta_pkg::*;

    logic signed [ANGLE_W-1:0] w_angle;
    assign w_angle = o_m_axis_tdata[ANGLE_W-1:0];

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // an empty or draining output stage frees the whole pipe
    a_rdy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    a_rdy_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |-> o_s_axis_tready)
        else $error("input blocked while output drains");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_angle <= ANGLE_LIMIT) && (w_angle >= -ANGLE_LIMIT))
        else $error("angle out of range");

endmodule

bind filtered_tilt_angle fta_chk u_fta_chk (.*);
